// ----- design/cdm_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the
// concentric disc mapper. No dependencies.
`timescale 1ns / 1ps

package cdm_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ANG_BITS         = 30;
  localparam int VEC_W            = 34;  // CORDIC x/y width, 30 fraction bits
  localparam int ZW               = 32;  // angle accumulator width
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // control that rides along the divider
  typedef struct packed {
    logic       vld;
    logic       centre;
    logic       neg;    // quotient enters theta negated
    logic [3:0] off;    // wedge offset in units of pi/4
  } div_ctl_t;

  // control that rides along the CORDIC stages
  typedef struct packed {
    logic       vld;
    logic       centre;
    logic [1:0] quad;
  } cor_ctl_t;

  // atan(2^-i) * 4/pi, 30 fraction bits
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 32'sd1073741824;
      1:  v = 32'sd633866811;
      2:  v = 32'sd334917815;
      3:  v = 32'sd170009512;
      4:  v = 32'sd85334662;
      5:  v = 32'sd42708931;
      6:  v = 32'sd21359677;
      7:  v = 32'sd10680490;
      8:  v = 32'sd5340327;
      9:  v = 32'sd2670173;
      10: v = 32'sd1335088;
      11: v = 32'sd667544;
      12: v = 32'sd333772;
      13: v = 32'sd166886;
      14: v = 32'sd83443;
      15: v = 32'sd41722;
      16: v = 32'sd20861;
      17: v = 32'sd10430;
      18: v = 32'sd5215;
      19: v = 32'sd2608;
      20: v = 32'sd1304;
      21: v = 32'sd652;
      22: v = 32'sd326;
      23: v = 32'sd163;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/concentric_disc_mapper.sv -----
// Concentric disc mapper top level: wedge select, pipelined divider,
// pipelined CORDIC, output rounding. Depends on cdm_pkg, cdm_div_stage, cdm_cordic_stage.
`timescale 1ns / 1ps

// Maps a point (u, v) of the unit square, each an unsigned 16-bit fraction,
// onto the unit disc with the concentric (wedge) mapping and returns
// (disc_x, disc_y) in signed Q1.16. One request is taken every clock and
// one result leaves every clock while the output is not stalled. The
// stages are a wedge-select stage, one stage per quotient bit of the
// restoring divider (FRAC_BITS + 1), one stage for the angle reduction and
// the radius times CORDIC gain multiply, one stage per CORDIC rotation and
// the output register. The whole pipeline advances together and holds
// when the output register is full and not taken, so a stall loses
// nothing. The exact centre maps to (0, 0).
module concentric_disc_mapper
  import cdm_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] square_u, [31:16] square_v
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [17:0] disc_x, [35:18] disc_y, [39:36] zero
);

  localparam int SW    = FRAC_BITS + 2;   // recentred coordinate
  localparam int RW    = FRAC_BITS + 1;   // radius / quotient
  localparam int TW    = FRAC_BITS + 5;   // theta
  localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int NDIV  = FRAC_BITS + 1;

  logic adv;  // whole pipeline moves
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- wedge select ----------------
  logic signed [17:0]  raw_u, raw_v;
  logic signed [SW-1:0] sx, sy, nsx, nsy;
  div_ctl_t            wctl;
  logic [RW-1:0]       w_r, w_a;

  assign raw_u = $signed({1'b0, in_tdata[15:0], 1'b0}) - 18'sd65536;
  assign raw_v = $signed({1'b0, in_tdata[31:16], 1'b0}) - 18'sd65536;

  generate
    if (FRAC_BITS >= 16) begin : g_up
      assign sx = SW'(raw_u) <<< (FRAC_BITS - 16);
      assign sy = SW'(raw_v) <<< (FRAC_BITS - 16);
    end else begin : g_dn
      assign sx = SW'(raw_u >>> (16 - FRAC_BITS));
      assign sy = SW'(raw_v >>> (16 - FRAC_BITS));
    end
  endgenerate

  assign nsx = -sx;
  assign nsy = -sy;

  always_comb begin
    wctl.vld    = in_tvalid;
    wctl.centre = (sx == '0) && (sy == '0);
    wctl.neg    = 1'b0;
    wctl.off    = 4'd0;
    w_r         = RW'(1);
    w_a         = '0;
    if (sx >= nsy) begin
      if (sx > sy) begin
        w_r      = RW'(sx);
        w_a      = sy[SW-1] ? RW'(nsy) : RW'(sy);
        wctl.neg = sy[SW-1];
        // on or below the x axis the angle wraps to a full turn
        wctl.off = (sy[SW-1] || (sy == '0)) ? 4'd8 : 4'd0;
      end else begin
        w_r      = RW'(sy);
        w_a      = sx[SW-1] ? RW'(nsx) : RW'(sx);
        wctl.neg = !sx[SW-1];
        wctl.off = 4'd2;
      end
    end else begin
      if (sx <= sy) begin
        w_r      = RW'(nsx);
        w_a      = sy[SW-1] ? RW'(nsy) : RW'(sy);
        wctl.neg = !sy[SW-1];
        wctl.off = 4'd4;
      end else begin
        w_r      = RW'(nsy);
        w_a      = sx[SW-1] ? RW'(nsx) : RW'(sx);
        wctl.neg = sx[SW-1];
        wctl.off = 4'd6;
      end
    end
    if (wctl.centre) begin
      w_r = RW'(1);   // keep the divider away from zero
      w_a = '0;
    end
  end

  // stage 0 register feeds the divider chain
  div_ctl_t      dctl [0:NDIV];
  logic [RW-1:0] dr   [0:NDIV];
  logic [RW-1:0] drem [0:NDIV];
  logic [RW-1:0] dq   [0:NDIV];
  div_ctl_t      s0_ctl_r;
  logic [RW-1:0] s0_r_r, s0_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      s0_ctl_r <= wctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r_r <= w_r;
      s0_a_r <= w_a;
    end
  end

  assign dctl[0] = s0_ctl_r;
  assign dr[0]   = s0_r_r;
  assign drem[0] = s0_a_r;
  assign dq[0]   = '0;

  // ---------------- divider: |num| * 2^F / r ----------------
  generate
    for (genvar j = 0; j < NDIV; j++) begin : g_div
      cdm_div_stage #(
        .FRAC_BITS (FRAC_BITS),
        .FIRST     (j == 0)
      ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .ctl_i (dctl[j]),
        .r_i   (dr[j]),
        .rem_i (drem[j]),
        .q_i   (dq[j]),
        .ctl_o (dctl[j+1]),
        .r_o   (dr[j+1]),
        .rem_o (drem[j+1]),
        .q_o   (dq[j+1])
      );
    end
  endgenerate

  // ---------------- angle reduction and radius scaling ----------------
  div_ctl_t                 dv;
  logic signed [TW-1:0]     qs, theta, zf;
  logic [2:0]               kq;
  logic [RW+29:0]           prod;
  cor_ctl_t                 th_ctl_nxt, th_ctl_r;
  logic signed [VEC_W-1:0]  x0_r;
  logic signed [ZW-1:0]     z0_r, z0_nxt;

  assign dv = dctl[NDIV];

  always_comb begin
    qs     = dv.neg ? -$signed(TW'(dq[NDIV])) : $signed(TW'(dq[NDIV]));
    theta  = ($signed(TW'(dv.off)) <<< FRAC_BITS) + qs;
    // quarter turns: floor((theta + 1) / 2), theta is never negative
    kq     = 3'((theta + (TW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
    zf     = theta - ($signed(TW'(kq)) <<< (FRAC_BITS + 1));
    z0_nxt = ZW'(zf) <<< (ANG_BITS - FRAC_BITS);
    prod   = dr[NDIV] * GAIN_Q30;
    th_ctl_nxt.vld    = dv.vld;
    th_ctl_nxt.centre = dv.centre;
    th_ctl_nxt.quad   = kq[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      th_ctl_r <= th_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= $signed(VEC_W'(prod >> FRAC_BITS));
      z0_r <= z0_nxt;
    end
  end

  // ---------------- CORDIC ----------------
  cor_ctl_t                cctl [0:NSTEP];
  logic signed [VEC_W-1:0] cx   [0:NSTEP];
  logic signed [VEC_W-1:0] cy   [0:NSTEP];
  logic signed [ZW-1:0]    cz   [0:NSTEP];

  assign cctl[0] = th_ctl_r;
  assign cx[0]   = x0_r;
  assign cy[0]   = '0;
  assign cz[0]   = z0_r;

  generate
    for (genvar i = 0; i < NSTEP; i++) begin : g_cor
      cdm_cordic_stage #(
        .STEP (i)
      ) u_cor (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .ctl_i (cctl[i]),
        .x_i   (cx[i]),
        .y_i   (cy[i]),
        .z_i   (cz[i]),
        .ctl_o (cctl[i+1]),
        .x_o   (cx[i+1]),
        .y_o   (cy[i+1]),
        .z_o   (cz[i+1])
      );
    end
  endgenerate

  // ---------------- quadrant, rounding, saturation ----------------
  cor_ctl_t                fc;
  logic signed [VEC_W-1:0] rx, ry, tx, ty;
  logic signed [17:0]      ox, oy;
  logic                    out_vld_r;
  logic signed [17:0]      ox_r, oy_r;

  localparam logic signed [VEC_W-1:0] HALF = VEC_W'(1) <<< (ANG_BITS - 17);
  localparam logic signed [VEC_W-1:0] SMAX = VEC_W'(65536);

  assign fc = cctl[NSTEP];

  always_comb begin
    unique case (fc.quad)
      2'd1:    begin rx = -cy[NSTEP]; ry =  cx[NSTEP]; end
      2'd2:    begin rx = -cx[NSTEP]; ry = -cy[NSTEP]; end
      2'd3:    begin rx =  cy[NSTEP]; ry = -cx[NSTEP]; end
      default: begin rx =  cx[NSTEP]; ry =  cy[NSTEP]; end
    endcase
    tx = (rx + HALF) >>> (ANG_BITS - 16);
    ty = (ry + HALF) >>> (ANG_BITS - 16);
    if (tx > SMAX)       tx = SMAX;
    else if (tx < -SMAX) tx = -SMAX;
    if (ty > SMAX)       ty = SMAX;
    else if (ty < -SMAX) ty = -SMAX;
    ox = fc.centre ? 18'sd0 : 18'(tx);
    oy = fc.centre ? 18'sd0 : 18'(ty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fc.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= ox;
      oy_r <= oy;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, oy_r, ox_r};

`ifndef ASSERT_OFF
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ox_r >= -18'sd65536) && (ox_r <= 18'sd65536) &&
                   (oy_r >= -18'sd65536) && (oy_r <= 18'sd65536))
    else $error("disc output outside unit range");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv.vld |-> (dq[NDIV] <= (RW'(1) << FRAC_BITS)))
    else $error("divider quotient above one");

  a_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    dv.vld |-> (kq <= 3'd4))
    else $error("theta reduced past a full turn");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(th_ctl_r) && $stable(s0_ctl_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ----- design/cdm_div_stage.sv -----
// One restoring-division stage: one quotient bit per stage.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_div_stage
  import cdm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  div_ctl_t           ctl_i,
  input  logic [FRAC_BITS:0] r_i,
  input  logic [FRAC_BITS:0] rem_i,
  input  logic [FRAC_BITS:0] q_i,
  output div_ctl_t           ctl_o,
  output logic [FRAC_BITS:0] r_o,
  output logic [FRAC_BITS:0] rem_o,
  output logic [FRAC_BITS:0] q_o
);

  div_ctl_t           ctl_r;
  logic [FRAC_BITS:0] r_r, rem_r, q_r;
  logic [FRAC_BITS:0] part, rem_nxt;
  logic               bit_q;

  always_comb begin
    // remainder stays below r <= 2^F, so doubling never drops a bit
    part    = FIRST ? rem_i : {rem_i[FRAC_BITS-1:0], 1'b0};
    bit_q   = (part >= r_i);
    rem_nxt = bit_q ? (part - r_i) : part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_i;
      rem_r <= rem_nxt;
      q_r   <= {q_i[FRAC_BITS-1:0], bit_q};
    end
  end

  assign ctl_o = ctl_r;
  assign r_o   = r_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

// ----- design/cdm_cordic_stage.sv -----
// One CORDIC rotation step with its own register.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_cordic_stage
  import cdm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  cor_ctl_t                ctl_i,
  input  logic signed [VEC_W-1:0] x_i,
  input  logic signed [VEC_W-1:0] y_i,
  input  logic signed [ZW-1:0]    z_i,
  output cor_ctl_t                ctl_o,
  output logic signed [VEC_W-1:0] x_o,
  output logic signed [VEC_W-1:0] y_o,
  output logic signed [ZW-1:0]    z_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STEP);

  cor_ctl_t                ctl_r;
  logic signed [VEC_W-1:0] x_r, y_r, dx, dy, x_nxt, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// ----- dv/tb.sv -----
// Testbench for concentric_disc_mapper: square points in, disc points out.
// Predicts each point with a fixed-point wedge/divide/CORDIC model; needs cdm_pkg.
`timescale 1ns / 1ps

module tb;
  import cdm_pkg::*;

  localparam int FB     = 16;
  localparam int STEPS  = 16;
  localparam int LAT    = FB + STEPS + 4;
  localparam longint ATAN_TBL [ATAN_ENTRIES] = '{
    1073741824, 633866811, 334917815, 170009512, 85334662, 42708931,
    21359677, 10680490, 5340327, 2670173, 1335088, 667544,
    333772, 166886, 83443, 41722, 20861, 10430,
    5215, 2608, 1304, 652, 326, 163};

  typedef struct packed {
    logic signed [17:0] y;
    logic signed [17:0] x;
  } disc_pt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] square_u, [31:16] square_v
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [17:0] disc_x, [35:18] disc_y, [39:36] zero

  disc_pt_t    disc_pts_due[$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycle_cnt = 0;

  concentric_disc_mapper u_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  // Wedge select, truncating divide, quarter-turn reduction, CORDIC, round
  function automatic disc_pt_t map_to_disc(logic [15:0] u, logic [15:0] v);
    longint one = 64'sd1 << FB;
    longint sx, sy, r, th, k, x, y, z, t, dx, dy;
    logic [1:0] quad;
    disc_pt_t pt;
    sx = 2 * longint'(u) - 65536;
    sy = 2 * longint'(v) - 65536;
    if (sx == 0 && sy == 0) return '0;
    if (sx >= -sy) begin
      if (sx > sy) begin
        r = sx;
        t = (sy * one) / r;
        th = (sy > 0) ? t : 8 * one + t;
      end else begin
        r = sy;
        th = 2 * one - (sx * one) / r;
      end
    end else begin
      if (sx <= sy) begin
        r = -sx;
        th = 4 * one - (sy * one) / r;
      end else begin
        r = -sy;
        th = 6 * one + (sx * one) / r;
      end
    end
    k = floor_sh(th + one, FB + 1);
    quad = k[1:0];
    z = (th - k * 2 * one) <<< (ANG_BITS - FB);
    x = floor_sh(r * longint'(GAIN_Q30), FB);
    y = 0;
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    case (quad)
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    x = floor_sh(x + (64'sd1 << 13), 14);
    y = floor_sh(y + (64'sd1 << 13), 14);
    if (x > 65536) x = 65536;
    if (x < -65536) x = -65536;
    if (y > 65536) y = 65536;
    if (y < -65536) y = -65536;
    pt.x = x[17:0];
    pt.y = y[17:0];
    return pt;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Result checker; receiver stalls at the current rate
  always @(posedge clk) begin
    disc_pt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (disc_pts_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = disc_pts_due.pop_front();
        if ($signed(out_tdata[17:0]) !== want.x)
          report_mismatch("disc_x", $signed(out_tdata[17:0]), want.x);
        if ($signed(out_tdata[35:18]) !== want.y)
          report_mismatch("disc_y", $signed(out_tdata[35:18]), want.y);
        if (out_tdata[39:36] !== 4'd0)
          report_mismatch("pad bits", out_tdata[39:36], 0);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one request, with an optional random gap before it
  task automatic send_point(logic [15:0] u, logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    disc_pts_due.push_back(map_to_disc(u, v));
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_quiet();
    while (disc_pts_due.size() != 0) @(posedge clk);
  endtask

  // Corners, axes, centre, diagonals (wedge ties)
  task automatic test_directed();
    logic [15:0] pts [][2] = '{
      '{16'h8000, 16'h8000}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF},
      '{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000}, '{16'hFFFF, 16'h8000},
      '{16'h0000, 16'h8000}, '{16'h8000, 16'hFFFF}, '{16'h8000, 16'h0000},
      '{16'hC000, 16'hC000}, '{16'h4000, 16'h4000}, '{16'hC000, 16'h4000},
      '{16'h4000, 16'hC000}, '{16'h8001, 16'h8000}, '{16'h8000, 16'h8001},
      '{16'h7FFF, 16'h8000}, '{16'h8000, 16'h7FFF}, '{16'hAAAA, 16'h5555},
      '{16'h5555, 16'hAAAA}, '{16'h8001, 16'h7FFF}};
    foreach (pts[i]) send_point(pts[i][0], pts[i][1]);
    drain();
  endtask

  // Random points; some near the centre and the diagonals
  task automatic test_random(int n, int idle, int stall);
    logic [15:0] u, v;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      u = 16'($urandom);
      case ($urandom_range(3))
        0: v = u;
        1: v = 16'(17'h10000 - u);
        2: begin
          u = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
          v = 16'h8000 + 16'($urandom_range(8)) - 16'd4;
        end
        default: v = 16'($urandom);
      endcase
      send_point(u, v);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 48, 0);
    test_random(250, 0, 48);
    test_random(250, 30, 30);
    go_quiet();
    repeat (LAT + 10) @(posedge clk);
    if (n_errors == 0 && disc_pts_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
